[design/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// shared types and constants of the midpoint circle rasterizer
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int OffWidth    = 6;
  localparam int DecWidth    = 12;
  localparam int SetWidth    = 8;
  localparam int DimWidth    = 13;
  localparam int RegWidth    = 32;
  localparam int AddrWidth   = 4;
  localparam int MaxResults  = 48;
  localparam int CntWidth    = $clog2(MaxResults);
  localparam int MinSetting  = 4;
  localparam int DecBase     = 3;
  localparam int StepInc     = 6;
  localparam int DiagInc     = 10;
  localparam int MirrorCount = 8;

  localparam logic [SetWidth-1:0] RadiusReset = SetWidth'(4);
  localparam logic [DimWidth-1:0] WidthReset  = DimWidth'(1920);
  localparam logic [DimWidth-1:0] HeightReset = DimWidth'(1080);

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SetWidth-1:0] radius_setting;
    logic [DimWidth-1:0] screen_width;
    logic [DimWidth-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [OffWidth-1:0]        x;
    logic [OffWidth-1:0]        y;
    logic signed [DecWidth-1:0] d;
  } step_state_t;

  typedef struct packed {
    step_state_t next;
    logic        done;
  } step_result_t;

endpackage

[design/mcr_if.sv]
// ----------------------------------------------------------------------------
// mcr_in_if / mcr_out_if
// valid/ready channels for circle centers and rasterizer results
// ----------------------------------------------------------------------------
interface mcr_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;

  modport source (output valid, center_x, center_y, input ready);
  modport sink   (input valid, center_x, center_y, output ready);
endinterface

interface mcr_out_if;
  import mcr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OffWidth-1:0]      offset_x;
  logic [OffWidth-1:0]      offset_y;
  logic [MirrorCount-1:0]   visible_mask;
  logic                     last;

  modport source (output valid, offset_x, offset_y, visible_mask, last, input ready);
  modport sink   (input valid, offset_x, offset_y, visible_mask, last, output ready);
endinterface

[design/mcr_regs.sv]
// ----------------------------------------------------------------------------
// mcr_regs
// apb register file: radius setting and screen size
// ----------------------------------------------------------------------------
module mcr_regs
  import mcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [RegWidth-1:0]  pwdata,
  output logic [RegWidth-1:0]  prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius_setting <= RadiusReset;
      cfg.screen_width   <= WidthReset;
      cfg.screen_height  <= HeightReset;
    end else if (wr_en) begin
      case (idx)
        REG_RADIUS: cfg.radius_setting <= pwdata[SetWidth-1:0];
        REG_WIDTH:  cfg.screen_width   <= pwdata[DimWidth-1:0];
        REG_HEIGHT: cfg.screen_height  <= pwdata[DimWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS: prdata = RegWidth'(cfg.radius_setting);
      REG_WIDTH:  prdata = RegWidth'(cfg.screen_width);
      REG_HEIGHT: prdata = RegWidth'(cfg.screen_height);
      default:    prdata = '0;
    endcase
  end

endmodule

[design/mcr_step.sv]
// ----------------------------------------------------------------------------
// mcr_step
// midpoint decision update, one octant step per use
// ----------------------------------------------------------------------------
module mcr_step
  import mcr_pkg::*;
(
  input  step_state_t  cur,
  output step_result_t res
);

  logic [OffWidth:0]          x_nx;
  logic [OffWidth:0]          y_nx;
  logic signed [DecWidth-1:0] xd;
  logic signed [DecWidth-1:0] yd;
  logic signed [DecWidth-1:0] delta;
  logic                       neg;

  assign neg = cur.d[DecWidth-1];
  assign xd  = signed'(DecWidth'(cur.x));
  assign yd  = signed'(DecWidth'(cur.y));

  // d negative: 4x+6, otherwise diagonal: 4(x-y)+10
  assign delta = neg ? (xd <<< 2) + DecWidth'(StepInc)
                     : ((xd - yd) <<< 2) + DecWidth'(DiagInc);

  assign x_nx = {1'b0, cur.x} + (OffWidth+1)'(1);
  assign y_nx = neg ? {1'b0, cur.y} : {1'b0, cur.y} - (OffWidth+1)'(1);

  assign res.next.x = x_nx[OffWidth-1:0];
  assign res.next.y = y_nx[OffWidth-1:0];
  assign res.next.d = cur.d + delta;
  assign res.done   = x_nx > y_nx;

endmodule

[design/mcr_clip.sv]
// ----------------------------------------------------------------------------
// mcr_clip
// screen clipping of the eight mirrored points around the center
// ----------------------------------------------------------------------------
module mcr_clip
  import mcr_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic [OffWidth-1:0]           off_x,
  input  logic [OffWidth-1:0]           off_y,
  input  logic [DimWidth-1:0]           screen_width,
  input  logic [DimWidth-1:0]           screen_height,
  output logic [MirrorCount-1:0]        mask
);

  localparam int EW = (COORD_WIDTH + 2 > DimWidth + 2) ? COORD_WIDTH + 2 : DimWidth + 2;

  logic signed [EW-1:0] cxe, cye, oxe, oye;
  logic signed [EW-1:0] hs [4];
  logic signed [EW-1:0] vs [4];
  logic [3:0]           h_ok, v_ok;

  function automatic logic in_range(input logic signed [EW-1:0] s,
                                    input logic [DimWidth-1:0] lim);
    in_range = !s[EW-1] && (s[EW-2:0] < (EW-1)'(lim));
  endfunction

  assign cxe = EW'(cx);
  assign cye = EW'(cy);
  assign oxe = signed'(EW'(off_x));
  assign oye = signed'(EW'(off_y));

  // columns: cx+x, cx-x, cx+y, cx-y; rows: cy+y, cy-y, cy+x, cy-x
  assign hs[0] = cxe + oxe;
  assign hs[1] = cxe - oxe;
  assign hs[2] = cxe + oye;
  assign hs[3] = cxe - oye;
  assign vs[0] = cye + oye;
  assign vs[1] = cye - oye;
  assign vs[2] = cye + oxe;
  assign vs[3] = cye - oxe;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h_ok[i] = in_range(hs[i], screen_width);
      v_ok[i] = in_range(vs[i], screen_height);
    end
  end

  assign mask = {h_ok[3] & v_ok[3], h_ok[2] & v_ok[3],
                 h_ok[3] & v_ok[2], h_ok[2] & v_ok[2],
                 h_ok[1] & v_ok[1], h_ok[0] & v_ok[1],
                 h_ok[1] & v_ok[0], h_ok[0] & v_ok[0]};

endmodule

[design/midpoint_circle_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// midpoint circle octant walker with eight-way screen clipping
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          word
//   centers   in   valid/ready        center_x, center_y (signed)
//   results   out  valid/ready        offset_x, offset_y, visible_mask, last
//   apb       in   psel/penable       radius_setting, screen_width, screen_height
//
// a center is accepted in the idle state and checked in the check state;
// an on-screen circle then gives one word per cycle while the results
// channel does not stall, about 0.71*r + 1 words (at most 46), from the
// single decision-update unit that advances one octant step per such cycle
// reset (rst, synchronous) returns to idle with no word pending
// a stalled results channel freezes the walker; the next center is taken
// as soon as the walker is idle, even while the final word waits
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  mcr_in_if.sink               centers,
  mcr_out_if.source            results,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [RegWidth-1:0]  pwdata,
  output logic [RegWidth-1:0]  prdata,
  output logic                 pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_RUN
  } state_t;

  state_t                        state;
  cfg_t                          cfg;
  logic signed [COORD_WIDTH-1:0] cx, cy;
  step_state_t                   cur;
  step_result_t                  res;
  logic [CntWidth-1:0]           count;
  logic [MirrorCount-1:0]        mask;
  logic [SetWidth-1:0]           eff_setting;
  logic                          slot_free;
  logic                          last_word;

  // output register
  logic                          out_valid;
  logic [OffWidth-1:0]           out_x, out_y;
  logic [MirrorCount-1:0]        out_mask;
  logic                          out_last;

  mcr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcr_step u_step (
    .cur (cur),
    .res (res)
  );

  // in the check state the offsets are zero, so bit 0 is the center test
  mcr_clip #(.COORD_WIDTH(COORD_WIDTH)) u_clip (
    .cx            (cx),
    .cy            (cy),
    .off_x         (cur.x),
    .off_y         (cur.y),
    .screen_width  (cfg.screen_width),
    .screen_height (cfg.screen_height),
    .mask          (mask)
  );

  // small markers count as the minimum size
  assign eff_setting = (cfg.radius_setting < SetWidth'(MinSetting))
                       ? SetWidth'(MinSetting) : cfg.radius_setting;

  assign slot_free = !out_valid || results.ready;
  assign last_word = res.done || (count == CntWidth'(MaxResults - 1));

  assign centers.ready        = (state == S_IDLE);
  assign results.valid        = out_valid;
  assign results.offset_x     = out_x;
  assign results.offset_y     = out_y;
  assign results.visible_mask = out_mask;
  assign results.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      // in the run state a taken word is always replaced by the next one
      if (results.ready && state != S_RUN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (centers.valid) begin
            cx    <= centers.center_x;
            cy    <= centers.center_y;
            cur.x <= '0;
            cur.y <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (mask[0]) begin
            // start at (0, r) with d = 3 - setting/2
            cur.y <= eff_setting[SetWidth-1:2];
            cur.d <= DecWidth'(DecBase) - DecWidth'(eff_setting[SetWidth-1:1]);
            count <= '0;
            state <= S_RUN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_x     <= cur.x;
            out_y     <= cur.y;
            out_mask  <= mask;
            out_last  <= last_word;
            cur       <= res.next;
            count     <= count + CntWidth'(1);
            if (last_word) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/mcr_checker.sv]
// ----------------------------------------------------------------------------
// mcr_checker
// port-level checks on the rasterizer result stream
// ----------------------------------------------------------------------------
module mcr_checker
  import mcr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OffWidth-1:0]    offset_x,
  input logic [OffWidth-1:0]    offset_y,
  input logic [MirrorCount-1:0] visible_mask,
  input logic                   last,
  input logic                   pready
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(offset_x) && $stable(offset_y)
      && $stable(visible_mask) && $stable(last))
    else $error("result word changed while stalled");

  // the walk stays in one octant
  a_octant: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> offset_x <= offset_y)
    else $error("offset_x above offset_y");

  // reaching the diagonal ends the circle
  a_diag_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && offset_x == offset_y |-> last)
    else $error("diagonal word without last");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .offset_x     (results.offset_x),
  .offset_y     (results.offset_y),
  .visible_mask (results.visible_mask),
  .last         (results.last),
  .pready       (pready)
);

[sim/midpoint_circle_rasterizer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_test
// self-checking bench: circle centers in, octant words out, apb register setup
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_test;
  import mcr_pkg::*;

  localparam int CoordWidth   = 16;
  localparam int HalfPeriod   = 6;
  localparam int ResetCycles  = 3;
  localparam int SettleCycles = 8;       // accept + on-screen check, with margin
  localparam int CycleLimit   = 1000000;
  localparam int HoldCycles   = 600;     // long receiver stall
  localparam int Margin       = 70;      // random centers land this far around the screen
  localparam int PrintCap     = 40;

  typedef struct packed {
    logic [CoordWidth-1:0] col;
    logic [CoordWidth-1:0] row;
  } center_t;

  typedef struct packed {
    logic [OffWidth-1:0]    offset_x;
    logic [OffWidth-1:0]    offset_y;
    logic [MirrorCount-1:0] visible_mask;
    logic                   last;
  } circle_word_t;

  logic clk = 1'b0;
  logic rst;

  // apb side
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [RegWidth-1:0]  pwdata;
  logic [RegWidth-1:0]  prdata;
  logic                 pready;

  mcr_in_if #(.COORD_WIDTH(CoordWidth)) center_ch ();
  mcr_out_if result_ch ();

  midpoint_circle_rasterizer #(.COORD_WIDTH(CoordWidth)) uut (
    .clk     (clk),
    .rst     (rst),
    .centers (center_ch),
    .results (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HalfPeriod clk = ~clk;

  // shadow copy of the registers, updated at the edge that writes them
  int cfg_radius;
  int cfg_width;
  int cfg_height;

  center_t      pending_centers[$];
  circle_word_t expected_words[$];
  center_t      next_center;
  circle_word_t want;

  int queued_total   = 0;
  int accepted_total = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int hold_left;
  logic hold_start;
  logic quiet;              // no idling on either side

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  function automatic logic on_screen(int px, int py);
    return px >= 0 && py >= 0 && px < cfg_width && py < cfg_height;
  endfunction

  // bit order: (+x,+y) (-x,+y) (+x,-y) (-x,-y) (+y,+x) (-y,+x) (+y,-x) (-y,-x)
  function automatic logic [MirrorCount-1:0] mirror_visibility(int cx, int cy, int x, int y);
    logic [MirrorCount-1:0] m;
    m[0] = on_screen(cx + x, cy + y);
    m[1] = on_screen(cx - x, cy + y);
    m[2] = on_screen(cx + x, cy - y);
    m[3] = on_screen(cx - x, cy - y);
    m[4] = on_screen(cx + y, cy + x);
    m[5] = on_screen(cx - y, cy + x);
    m[6] = on_screen(cx + y, cy - x);
    m[7] = on_screen(cx - y, cy - x);
    return m;
  endfunction

  // walk one octant and queue the words the block should give for this center
  task automatic trace_circle(input logic [CoordWidth-1:0] col_raw,
                              input logic [CoordWidth-1:0] row_raw);
    int cx, cy, setting, d, x, y, n;
    circle_word_t w;
    cx = $signed(col_raw);
    cy = $signed(row_raw);
    setting = (cfg_radius < MinSetting) ? MinSetting : cfg_radius;
    if (!on_screen(cx, cy)) return;     // off-screen center gives nothing
    d = DecBase - (setting >> 1);
    y = setting >> 2;
    x = 0;
    n = 0;
    while (x <= y && n < MaxResults) begin
      w.offset_x     = OffWidth'(x);
      w.offset_y     = OffWidth'(y);
      w.visible_mask = mirror_visibility(cx, cy, x, y);
      n++;
      if (d < 0) begin
        d += 4 * x + StepInc;
      end else begin
        d += 4 * (x - y) + DiagInc;
        y--;
      end
      x++;
      w.last = !(x <= y && n < MaxResults);
      expected_words.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int wanted);
    if (error_count < PrintCap)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, wanted);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // center driver: takes the next pending center when the slot is free, after any random gap
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      center_ch.valid <= 1'b0;
    end else begin
      // accepted word: predict with the registers as they are now
      if (center_ch.valid && center_ch.ready) begin
        trace_circle(center_ch.center_x, center_ch.center_y);
        accepted_total++;
      end
      if (!center_ch.valid || center_ch.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          center_ch.valid <= 1'b0;
        end else if (pending_centers.size() != 0) begin
          next_center = pending_centers.pop_front();
          center_ch.valid    <= 1'b1;
          center_ch.center_x <= next_center.col;
          center_ch.center_y <= next_center.row;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          center_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: checks each word against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", result_ch.offset_x, 0);
        end else begin
          want = expected_words.pop_front();
          if (result_ch.offset_x !== want.offset_x)
            report_mismatch("offset_x", result_ch.offset_x, want.offset_x);
          if (result_ch.offset_y !== want.offset_y)
            report_mismatch("offset_y", result_ch.offset_y, want.offset_y);
          if (result_ch.visible_mask !== want.visible_mask)
            report_mismatch("visible_mask", result_ch.visible_mask, want.visible_mask);
          if (result_ch.last !== want.last)
            report_mismatch("last", result_ch.last, want.last);
        end
      end
      // ready: long hold first, then random stall bursts
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 14);
      end
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL midpoint_circle_rasterizer");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequencing helpers
  // --------------------------------------------------------------------------

  // setup cycle, access cycle; the register takes the value at the access edge
  task automatic apb_write(input reg_idx_t idx, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWidth'(4 * int'(idx));
    pwdata  <= RegWidth'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RADIUS: cfg_radius = value & 'hFF;
      REG_WIDTH:  cfg_width  = value & 'h1FFF;
      REG_HEIGHT: cfg_height = value & 'h1FFF;
      default: ;
    endcase
  endtask

  task automatic set_screen(input int radius, input int width, input int height);
    apb_write(REG_RADIUS, radius);
    apb_write(REG_WIDTH, width);
    apb_write(REG_HEIGHT, height);
  endtask

  task automatic queue_center(input int col, input int row);
    center_t c;
    c.col = CoordWidth'(col);
    c.row = CoordWidth'(row);
    pending_centers.push_back(c);
    queued_total++;
  endtask

  // mostly near the screen so clipping is exercised, some anywhere in range
  task automatic queue_random_centers(input int count);
    int col, row;
    repeat (count) begin
      if ($urandom_range(0, 9) < 2) begin
        col = int'($urandom_range(0, 65535)) - 32768;
        row = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        col = int'($urandom_range(0, cfg_width + 2 * Margin)) - Margin;
        row = int'($urandom_range(0, cfg_height + 2 * Margin)) - Margin;
      end
      queue_center(col, row);
    end
  endtask

  // idle: every center taken, every word seen, then room for a last
  // off-screen center to finish its check
  task automatic settle();
    while (accepted_total != queued_total || expected_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int radius, width, height, count;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    hold_start = 1'b0;
    quiet      = 1'b0;
    center_ch.valid    = 1'b0;
    center_ch.center_x = '0;
    center_ch.center_y = '0;
    result_ch.ready    = 1'b0;
    cfg_radius = RadiusReset;
    cfg_width  = WidthReset;
    cfg_height = HeightReset;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // reset registers: corners, just-off edges, coordinate extremes
    queue_center(0, 0);
    queue_center(1919, 1079);
    queue_center(1920, 500);
    queue_center(500, 1080);
    queue_center(-1, 0);
    queue_center(0, -1);
    queue_center(32767, 32767);
    queue_center(-32768, -32768);
    queue_center(960, 540);
    settle();

    // settings below the minimum clamp to radius one
    apb_write(REG_RADIUS, 0);
    queue_center(0, 0);
    queue_center(5, 5);
    settle();
    apb_write(REG_RADIUS, 3);
    queue_center(1, 1);
    settle();

    // largest marker on a 4096 by 4096 screen
    set_screen(255, 4096, 4096);
    queue_center(0, 0);
    queue_center(4095, 4095);
    queue_center(2048, 2048);
    queue_center(30, 4000);
    settle();

    // zero screen size: nothing is on screen
    set_screen(20, 0, 1080);
    queue_center(0, 0);
    queue_center(10, 10);
    settle();
    set_screen(20, 1920, 0);
    queue_center(0, 0);
    settle();

    // one-pixel screen
    set_screen(17, 1, 1);
    queue_center(0, 0);
    queue_center(0, 1);
    settle();

    // all width bits set
    set_screen(40, 8191, 8191);
    queue_center(8190, 8190);
    queue_center(-32768, 100);
    queue_center(100, 32767);
    settle();

    // random phases; one with a large marker and fewer centers
    for (int phase = 0; phase < 6; phase++) begin
      radius = (phase == 3) ? $urandom_range(200, 255) : $urandom_range(0, 48);
      width  = phase[0] ? $urandom_range(1, 80) : $urandom_range(1, 4096);
      height = phase[0] ? $urandom_range(1, 4096) : $urandom_range(1, 80);
      if (phase == 4) begin
        width  = $urandom_range(1, 4096);
        height = $urandom_range(1, 4096);
      end
      count = (phase == 3) ? 15 : 40;
      if (phase == 5) begin
        @(posedge clk);
        quiet <= 1'b1;
      end
      set_screen(radius, width, height);
      queue_random_centers(count);
      if (phase == 1) begin
        // stall the results side while centers keep coming
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      settle();
    end

    if (error_count == 0) begin
      $display("PASS midpoint_circle_rasterizer");
    end else begin
      $display("FAIL midpoint_circle_rasterizer");
    end
    $finish;
  end

endmodule
